// File: hdl/htu_pkg.sv
package htu_pkg;

  localparam int COEF_WIDTH_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int SLOT_W          = 16;
  localparam int MROW_W          = 64;
  localparam int IROW_W          = 48;
  localparam int CFG_IDX_W       = 3;

  localparam logic [MROW_W-1:0] MROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [MROW_W-1:0] MROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [MROW_W-1:0] MROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [MROW_W-1:0] MROW3_RST = 64'h1000_0000_0000_0000;
  localparam logic [IROW_W-1:0] IROW0_RST = 48'h0000_0000_1000;
  localparam logic [IROW_W-1:0] IROW1_RST = 48'h0000_1000_0000;
  localparam logic [IROW_W-1:0] IROW2_RST = 48'h1000_0000_0000;

  typedef enum logic [1:0] {
    OP_POINT  = 2'd0,
    OP_VECTOR = 2'd1,
    OP_NORMAL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MROW0 = 3'd0,
    REG_MROW1 = 3'd1,
    REG_MROW2 = 3'd2,
    REG_MROW3 = 3'd3,
    REG_IROW0 = 3'd4,
    REG_IROW1 = 3'd5,
    REG_IROW2 = 3'd6
  } cfg_reg_t;

endpackage

// File: hdl/homogeneous_transform_unit.sv
// Homogeneous 4x4 transform of one 3D word per cycle.
// Input channel: drive in_operation (point, direction vector or surface normal)
// and in_x/in_y/in_z (signed Q16.16); the word is taken at a clock edge with
// start high and busy low. busy stays low: the pipeline takes a word every cycle.
// Result channel: out_x/out_y/out_z and out_status appear for one cycle with
// out_valid high. There is no back pressure; the receiver must take every word.
// From accept to out_valid a word passes the product stage, the sum/saturate stage,
// the divide setup stage, one restoring-divide stage per quotient bit of the Q16.16
// quotient and the output register.
// Throughput: one word per cycle, results in accept order.
// Configuration: cfg_valid/cfg_ready write one matrix row at cfg_index; cfg_ready
// is always high. Write only while no word is in flight.
// Reset (synchronous, rst_n low): matrix and inverse rows load the identity,
// all pipeline valid bits clear, so in-flight words are dropped.
module homogeneous_transform_unit #(
  parameter int COEF_WIDTH  = htu_pkg::COEF_WIDTH_DEF,
  parameter int COORD_WIDTH = htu_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_operation,
  input  logic signed [htu_pkg::FIELD_W-1:0]     in_x,
  input  logic signed [htu_pkg::FIELD_W-1:0]     in_y,
  input  logic signed [htu_pkg::FIELD_W-1:0]     in_z,
  output logic                                   out_valid,
  output logic signed [htu_pkg::FIELD_W-1:0]     out_x,
  output logic signed [htu_pkg::FIELD_W-1:0]     out_y,
  output logic signed [htu_pkg::FIELD_W-1:0]     out_z,
  output logic [1:0]                             out_status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [htu_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [htu_pkg::MROW_W-1:0]             cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = COEF_WIDTH;
  localparam int EF   = COEF_WIDTH - 4;      // coefficient fraction bits
  localparam int CF   = COORD_WIDTH / 2;     // coordinate fraction bits
  localparam int PW   = CW + EW;             // product width
  localparam int SW   = PW + 2;              // four-term sum width
  localparam int SH   = CW - CF;
  localparam int XW   = CW + SH;
  localparam int FW   = htu_pkg::FIELD_W;
  localparam int LAT  = CW + 4;
  localparam logic [CW-1:0] ONE = CW'(1) << CF;

  // ---------------------------------------------------------------- config
  logic [htu_pkg::MROW_W-1:0] mrow_r [0:3];
  logic [htu_pkg::IROW_W-1:0] irow_r [0:2];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrow_r[0] <= htu_pkg::MROW0_RST;
      mrow_r[1] <= htu_pkg::MROW1_RST;
      mrow_r[2] <= htu_pkg::MROW2_RST;
      mrow_r[3] <= htu_pkg::MROW3_RST;
      irow_r[0] <= htu_pkg::IROW0_RST;
      irow_r[1] <= htu_pkg::IROW1_RST;
      irow_r[2] <= htu_pkg::IROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        htu_pkg::REG_MROW0: mrow_r[0] <= cfg_data;
        htu_pkg::REG_MROW1: mrow_r[1] <= cfg_data;
        htu_pkg::REG_MROW2: mrow_r[2] <= cfg_data;
        htu_pkg::REG_MROW3: mrow_r[3] <= cfg_data;
        htu_pkg::REG_IROW0: irow_r[0] <= cfg_data[htu_pkg::IROW_W-1:0];
        htu_pkg::REG_IROW1: irow_r[1] <= cfg_data[htu_pkg::IROW_W-1:0];
        htu_pkg::REG_IROW2: irow_r[2] <= cfg_data[htu_pkg::IROW_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ------------------------------------------------ stage 1: products
  // Select coefficients per operation and register floored products.
  // Column three holds the translation term (points only).
  logic                 accept;
  logic signed [PW-1:0] prod_nxt [0:3][0:3];
  logic signed [PW-1:0] prod_r   [0:3][0:3];
  logic                 s1_v_r;
  logic [1:0]           s1_op_r;

  assign accept = start && !busy;

  always_comb begin
    logic signed [EW-1:0] e;
    logic signed [PW-1:0] ce;
    logic signed [PW-1:0] xe;
    logic signed [CW-1:0] crd [0:2];
    crd[0] = in_x[CW-1:0];
    crd[1] = in_y[CW-1:0];
    crd[2] = in_z[CW-1:0];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (in_operation == htu_pkg::OP_NORMAL && i < 3)
          e = irow_r[j][htu_pkg::SLOT_W*i +: EW];
        else
          e = mrow_r[i][htu_pkg::SLOT_W*j +: EW];
        ce = PW'(e);
        xe = PW'(crd[j]);
        prod_nxt[i][j] = (ce * xe) >>> EF;
      end
      e  = mrow_r[i][htu_pkg::SLOT_W*3 +: EW];
      ce = PW'(e);
      if (in_operation == htu_pkg::OP_POINT)
        prod_nxt[i][3] = (ce <<< CF) >>> EF;
      else
        prod_nxt[i][3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    s1_op_r  <= in_operation;
    prod_r   <= prod_nxt;
  end

  // ------------------------------------------- stage 2: sums, saturate
  logic signed [CW-1:0] s2_p_nxt [0:3];
  logic signed [CW-1:0] s2_p_r   [0:3];
  logic                 s2_flag_nxt;
  logic                 s2_flag_r;
  logic                 s2_v_r;
  logic [1:0]           s2_op_r;

  always_comb begin
    logic signed [SW-1:0] s;
    logic                 fits;
    s2_flag_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      s = SW'(prod_r[i][0]) + SW'(prod_r[i][1]) + SW'(prod_r[i][2]) + SW'(prod_r[i][3]);
      fits = (s[SW-1:CW-1] == '0) || (s[SW-1:CW-1] == '1);
      if (fits) begin
        s2_p_nxt[i] = s[CW-1:0];
      end else begin
        s2_p_nxt[i] = s[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        // row three only counts for points
        if (i < 3 || s1_op_r == htu_pkg::OP_POINT) s2_flag_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_op_r   <= s1_op_r;
    s2_p_r    <= s2_p_nxt;
    s2_flag_r <= s2_flag_nxt;
  end

  // ------------------------------------------ stage 3: divide setup
  // Index 0 is the setup stage; index k+1 holds quotient bit k done.
  logic            dv_r   [0:CW];
  logic            ddiv_r [0:CW];
  logic [1:0]      dst_r  [0:CW];
  logic [CW-1:0]   dm_r   [0:CW];
  logic [2:0]      dneg_r [0:CW];
  logic [2:0]      dovf_r [0:CW];
  logic [CW-1:0]   drem_r [0:CW][0:2];
  logic [CW-1:0]   ddq_r  [0:CW][0:2];
  logic [CW-1:0]   dbyp_r [0:CW][0:2];

  logic            ddiv_nxt;
  logic [1:0]      dst_nxt;
  logic [CW-1:0]   dm_nxt;
  logic [2:0]      dneg_nxt;
  logic [2:0]      dovf_nxt;
  logic [CW-1:0]   drem_nxt [0:2];
  logic [CW-1:0]   ddq_nxt  [0:2];
  logic [CW-1:0]   dbyp_nxt [0:2];

  always_comb begin
    logic [CW-1:0] pm;
    logic          is_pt;
    is_pt    = (s2_op_r == htu_pkg::OP_POINT);
    ddiv_nxt = is_pt && (s2_p_r[3] != '0) && (s2_p_r[3] != ONE);
    dm_nxt   = s2_p_r[3][CW-1] ? CW'(-s2_p_r[3]) : s2_p_r[3];
    // the unused operation code always reports ok
    if (is_pt && s2_p_r[3] == '0)
      dst_nxt = htu_pkg::ST_DIV0;
    else if (s2_flag_r &&
             (s2_op_r inside {htu_pkg::OP_POINT, htu_pkg::OP_VECTOR, htu_pkg::OP_NORMAL}))
      dst_nxt = htu_pkg::ST_SAT;
    else
      dst_nxt = htu_pkg::ST_OK;
    for (int l = 0; l < 3; l++) begin
      pm          = s2_p_r[l][CW-1] ? CW'(-s2_p_r[l]) : s2_p_r[l];
      dneg_nxt[l] = s2_p_r[l][CW-1] ^ s2_p_r[3][CW-1];
      dovf_nxt[l] = XW'(pm) >= {dm_nxt, {SH{1'b0}}};
      drem_nxt[l] = CW'(pm >> SH);
      ddq_nxt[l]  = CW'({pm, {CF{1'b0}}});
      case (s2_op_r)
        htu_pkg::OP_POINT:  dbyp_nxt[l] = (s2_p_r[3] == '0) ? '0 : s2_p_r[l];
        htu_pkg::OP_VECTOR,
        htu_pkg::OP_NORMAL: dbyp_nxt[l] = s2_p_r[l];
        default:            dbyp_nxt[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= s2_v_r;
    end
    ddiv_r[0] <= ddiv_nxt;
    dst_r[0]  <= dst_nxt;
    dm_r[0]   <= dm_nxt;
    dneg_r[0] <= dneg_nxt;
    dovf_r[0] <= dovf_nxt;
    drem_r[0] <= drem_nxt;
    ddq_r[0]  <= ddq_nxt;
    dbyp_r[0] <= dbyp_nxt;
  end

  // ----------------------------------- restoring divide, bit per stage
  for (genvar k = 0; k < CW; k++) begin : g_div
    logic [CW-1:0] rem_nxt [0:2];
    logic [CW-1:0] dq_nxt  [0:2];

    always_comb begin
      logic [CW:0] sh;
      logic [CW:0] diff;
      for (int l = 0; l < 3; l++) begin
        sh   = {drem_r[k][l], ddq_r[k][l][CW-1]};
        diff = sh - {1'b0, dm_r[k]};
        if (!diff[CW]) begin
          rem_nxt[l] = diff[CW-1:0];
          dq_nxt[l]  = {ddq_r[k][l][CW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = sh[CW-1:0];
          dq_nxt[l]  = {ddq_r[k][l][CW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
      ddiv_r[k+1] <= ddiv_r[k];
      dst_r[k+1]  <= dst_r[k];
      dm_r[k+1]   <= dm_r[k];
      dneg_r[k+1] <= dneg_r[k];
      dovf_r[k+1] <= dovf_r[k];
      drem_r[k+1] <= rem_nxt;
      ddq_r[k+1]  <= dq_nxt;
      dbyp_r[k+1] <= dbyp_r[k];
    end
  end

  // ------------------------------------ final: sign, saturate, status
  logic signed [CW-1:0] res_nxt [0:2];
  logic [1:0]           st_nxt;
  logic                 out_valid_r;
  logic signed [FW-1:0] out_x_r, out_y_r, out_z_r;
  logic [1:0]           out_status_r;

  always_comb begin
    logic [CW-1:0] q;
    logic          qsat;
    logic          lane_sat;
    lane_sat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      q    = ddq_r[CW][l];
      qsat = 1'b0;
      if (!ddiv_r[CW]) begin
        res_nxt[l] = dbyp_r[CW][l];
      end else if (dneg_r[CW][l]) begin
        qsat       = dovf_r[CW][l] || (q > (CW'(1) << (CW-1)));
        res_nxt[l] = qsat ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
      end else begin
        qsat       = dovf_r[CW][l] || q[CW-1];
        res_nxt[l] = qsat ? {1'b0, {(CW-1){1'b1}}} : q;
      end
      lane_sat = lane_sat | qsat;
    end
    if (dst_r[CW] == htu_pkg::ST_DIV0)
      st_nxt = htu_pkg::ST_DIV0;
    else if (dst_r[CW] == htu_pkg::ST_SAT || lane_sat)
      st_nxt = htu_pkg::ST_SAT;
    else
      st_nxt = htu_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[CW];
    end
    out_x_r      <= FW'(res_nxt[0]);
    out_y_r      <= FW'(res_nxt[1]);
    out_z_r      <= FW'(res_nxt[2]);
    out_status_r <= st_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word did not come out after the pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without a matching accepted word");

  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == htu_pkg::ST_DIV0) |->
      (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero w result carries nonzero coordinates");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == htu_pkg::ST_OK || out_status == htu_pkg::ST_SAT ||
                   out_status == htu_pkg::ST_DIV0))
    else $error("result word carries an undefined status");
`endif

endmodule

// File: tb/tb_homogeneous_transform_unit.sv
module tb_homogeneous_transform_unit;

  localparam int LATENCY     = 36;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ONE_Q16     = 65536;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vertex_word_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  st;
  } xform_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [htu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [htu_pkg::MROW_W-1:0] cfg_data = '0;

  homogeneous_transform_unit u_top (.*);

  always #10 clk = ~clk;

  // Shadow copy of the matrix registers, updated as each write is taken.
  logic [63:0] mat_row [4];
  logic [47:0] inv_row [3];

  vertex_word_t pending_words[$];
  xform_word_t  expected_xforms[$];
  int  send_idle_pct = 0;
  int  errors = 0;
  int  checked = 0;
  int  cycles = 0;
  bit  cfg_pending = 1'b0;
  htu_pkg::cfg_reg_t cfg_reg_q;
  logic [63:0] cfg_val_q;

  function automatic longint coef(logic [63:0] row, int col);
    logic signed [15:0] e;
    e = row[16*col +: 16];
    return longint'(e);
  endfunction

  // Floor by the 12 fraction bits of the coefficient; >>> floors.
  function automatic longint mul_q(longint c, longint v);
    return (c * v) >>> 12;
  endfunction

  function automatic longint clamp32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic xform_word_t transform_vertex(vertex_word_t w);
    xform_word_t r;
    longint c[3], p[4], res[3], s, e;
    bit sat;
    sat = 1'b0;
    c[0] = longint'(signed'(w.x));
    c[1] = longint'(signed'(w.y));
    c[2] = longint'(signed'(w.z));
    res = '{0, 0, 0};
    r.st = htu_pkg::ST_OK;
    if (w.op == htu_pkg::OP_POINT) begin
      for (int i = 0; i < 4; i++) begin
        s = mul_q(coef(mat_row[i], 3), ONE_Q16);
        for (int j = 0; j < 3; j++) s += mul_q(coef(mat_row[i], j), c[j]);
        p[i] = clamp32(s, sat);
      end
      if (p[3] == 0) begin
        r.st = htu_pkg::ST_DIV0;
      end else begin
        // Divide in SV truncates toward zero, as the hardware does.
        for (int i = 0; i < 3; i++)
          res[i] = (p[3] == ONE_Q16) ? p[i] : clamp32((p[i] * ONE_Q16) / p[3], sat);
        r.st = sat ? htu_pkg::ST_SAT : htu_pkg::ST_OK;
      end
    end else if (w.op == htu_pkg::OP_VECTOR || w.op == htu_pkg::OP_NORMAL) begin
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) begin
          e = (w.op == htu_pkg::OP_VECTOR) ? coef(mat_row[i], j)
                                           : coef({16'h0, inv_row[j]}, i);
          s += mul_q(e, c[j]);
        end
        res[i] = clamp32(s, sat);
      end
      r.st = sat ? htu_pkg::ST_SAT : htu_pkg::ST_OK;
    end
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
    return r;
  endfunction

  // Driver: advance to the next queued word once the current one is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!start || !busy) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          vertex_word_t w;
          w = pending_words.pop_front();
          start <= 1'b1;
          in_operation <= w.op;
          in_x <= w.x;
          in_y <= w.y;
          in_z <= w.z;
        end else begin
          start <= 1'b0;
        end
      end
      cfg_valid <= cfg_pending;
      cfg_index <= cfg_reg_q;
      cfg_data  <= cfg_val_q;
    end
  end

  // Monitor: predict on accept, check each result word against the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        vertex_word_t w;
        w.op = in_operation;
        w.x = in_x;
        w.y = in_y;
        w.z = in_z;
        expected_xforms.push_back(transform_vertex(w));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= htu_pkg::REG_MROW3) mat_row[cfg_index[1:0]] = cfg_data;
        else inv_row[2'(cfg_index - htu_pkg::REG_IROW0)] = cfg_data[47:0];
        cfg_pending = 1'b0;
      end
      if (out_valid) begin
        if (expected_xforms.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          xform_word_t e;
          e = expected_xforms.pop_front();
          checked++;
          if (out_x !== e.x) begin
            $error("out_x expected %h actual %h", e.x, out_x);
            errors++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %h actual %h", e.y, out_y);
            errors++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %h actual %h", e.z, out_z);
            errors++;
          end
          if (out_status !== e.st) begin
            $error("out_status expected %0d actual %0d", e.st, out_status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results checked", cycles, checked);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'(signed'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic queue_word(htu_pkg::op_t op, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
    vertex_word_t w;
    w.op = op;
    w.x = x;
    w.y = y;
    w.z = z;
    pending_words.push_back(w);
  endtask

  // Hold until every queued word has come back, then let the pipe drain.
  task automatic drain();
    while (pending_words.size() > 0 || expected_xforms.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(htu_pkg::cfg_reg_t r, logic [63:0] v);
    cfg_reg_q = r;
    cfg_val_q = v;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_matrix(int kind);
    logic [63:0] v;
    for (int r = 0; r < 7; r++) begin
      case (kind)
        0: v = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        1: v = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
        default: v = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
      endcase
      // A fixed w row giving w of exactly one or zero keeps those paths busy.
      if (kind == 3 && r == htu_pkg::REG_MROW3) v = {16'h1000, 16'h0, 16'h0, 16'h0};
      if (kind == 4 && r == htu_pkg::REG_MROW3) v = '0;
      write_reg(htu_pkg::cfg_reg_t'(r), v);
    end
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++)
      queue_word(htu_pkg::op_t'($urandom_range(9) == 0 ? 3 : $urandom_range(2)),
                 rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    cfg_reg_q = htu_pkg::REG_MROW0;
    cfg_val_q = '0;
    mat_row = '{htu_pkg::MROW0_RST, htu_pkg::MROW1_RST, htu_pkg::MROW2_RST,
                htu_pkg::MROW3_RST};
    inv_row = '{htu_pkg::IROW0_RST, htu_pkg::IROW1_RST, htu_pkg::IROW2_RST};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identity passes w=1 unchanged; extremes, unused code.
    queue_word(htu_pkg::OP_POINT, 32'h0001_0000, 32'hffff_0000, 32'h0);
    queue_word(htu_pkg::OP_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    queue_word(htu_pkg::OP_VECTOR, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    queue_word(htu_pkg::OP_NORMAL, 32'h1234_5678, 32'hedcb_a988, 32'h8000_0000);
    queue_word(htu_pkg::op_t'(2'd3), 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    drain();
    // Zero w row: every point reports a divide by zero.
    write_reg(htu_pkg::REG_MROW3, '0);
    queue_word(htu_pkg::OP_POINT, 32'h0003_0000, 32'h0, 32'h0);
    queue_word(htu_pkg::OP_VECTOR, 32'h0003_0000, 32'h0, 32'h0);
    drain();
    // Translation only in w: points take the divide path.
    write_reg(htu_pkg::REG_MROW3, {16'h2000, 16'h0, 16'h0, 16'h0});
    write_reg(htu_pkg::REG_MROW0, {16'h7fff, 16'h1000, 16'h0, 16'h1000});
    queue_word(htu_pkg::OP_POINT, 32'h0002_8000, 32'h7fff_ffff, 32'h8000_0000);
    queue_word(htu_pkg::OP_POINT, 32'hfffd_0001, 32'h1, 32'h0);
    drain();
    // Largest and most negative entries drive large sums into saturation.
    load_matrix(0);
    random_words(6);
    drain();
    load_matrix(1);
    random_words(6);
    drain();

    // Random phases: idle 0, 86, 32 percent, each over a few matrices.
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 86 : 32;
      load_matrix(2 + ph % 3);
      random_words(50);
      drain();
    end
    send_idle_pct = 0;
    drain();

    $display("checked %0d transform results across 17 matrix settings", checked);
    $display("all operations, saturation, w of one and zero w exercised");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
